// File: sv/assert_macros.svh
// assertion macros used by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every rising clock edge out of reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: sv/jeop_pkg.sv
// constants, codes and the exif signature table for the orientation parser
package jeop_pkg;

  // parse phase codes
  localparam logic [4:0] PH_SOI     = 5'd0;
  localparam logic [4:0] PH_MARKER  = 5'd1;
  localparam logic [4:0] PH_LENGTH  = 5'd2;
  localparam logic [4:0] PH_APPLEN  = 5'd3;
  localparam logic [4:0] PH_SKIPSEG = 5'd4;
  localparam logic [4:0] PH_SIG     = 5'd5;
  localparam logic [4:0] PH_ORDER   = 5'd6;
  localparam logic [4:0] PH_MAGIC   = 5'd7;
  localparam logic [4:0] PH_OFFSET  = 5'd8;
  localparam logic [4:0] PH_SKIPIFD = 5'd9;
  localparam logic [4:0] PH_COUNT   = 5'd10;
  localparam logic [4:0] PH_TAG     = 5'd11;
  localparam logic [4:0] PH_TYPE    = 5'd12;
  localparam logic [4:0] PH_TCOUNT  = 5'd13;
  localparam logic [4:0] PH_VALUE   = 5'd14;
  localparam logic [4:0] PH_SKIPENT = 5'd15;
  localparam logic [4:0] PH_DONE    = 5'd16;

  // result status codes
  localparam logic [3:0] ST_FOUND      = 4'd0;
  localparam logic [3:0] ST_NOT_JPEG   = 4'd1;
  localparam logic [3:0] ST_NO_EXIF    = 4'd2;
  localparam logic [3:0] ST_BAD_SIG    = 4'd3;
  localparam logic [3:0] ST_BAD_TIFF   = 4'd4;
  localparam logic [3:0] ST_BAD_COUNT  = 4'd5;
  localparam logic [3:0] ST_TAG_ABSENT = 4'd6;
  localparam logic [3:0] ST_TRUNCATED  = 4'd7;
  localparam logic [3:0] ST_MALFORMED  = 4'd8;

  // marker and header values
  localparam logic [31:0] MK_SOI       = 32'h0000_FFD8;
  localparam logic [31:0] MK_APP1      = 32'h0000_FFE1;
  localparam logic [31:0] MK_SOS       = 32'h0000_FFDA;
  localparam logic [31:0] MK_EOI       = 32'h0000_FFD9;
  localparam logic [31:0] TIFF_LE      = 32'h0000_4949;
  localparam logic [31:0] TIFF_BE      = 32'h0000_4D4D;
  localparam logic [31:0] TIFF_MAGIC   = 32'h0000_002A;
  localparam logic [31:0] TAG_ORIENT   = 32'h0000_0112;
  localparam logic [31:0] SEG_LEN_MIN  = 32'd2;
  localparam logic [31:0] IFD_OFS_MIN  = 32'd8;
  localparam logic [31:0] ENTRY_REST   = 32'd10;
  localparam logic [2:0]  SIG_LAST_POS = 3'd5;

  // exif signature "Exif\0\0"
  function automatic logic [7:0] sig_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h45;
      3'd1:    b = 8'h78;
      3'd2:    b = 8'h69;
      3'd3:    b = 8'h66;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: sv/jpeg_exif_orientation_parser.sv
// Exif orientation parser: takes one JPEG file byte per cycle and gives
// at most one result per file. The byte is decoded against the parse state in
// the cycle it is accepted; its result, if any, goes to the output register
// or, while that one is held, to the skid register. One byte is taken every
// cycle; in_ready_o drops only when a result waits in the output register
// and a second one waits in the skid register behind it. Segments, the gap
// to IFD0 and the unused 10 bytes of each IFD entry are skipped byte by byte
// with a 32-bit down counter. After a result the remaining bytes are dropped
// until the byte marked last, which rearms the parser for the next file; a
// file that ends before any result gives status truncated on its last byte.

`include "assert_macros.svh"

module jpeg_exif_orientation_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic [15:0] orientation_o
);
  import jeop_pkg::*;

  logic [4:0]  phase_q, phase_d;
  logic [2:0]  fbi_q, fbi_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] skip_q, skip_d;
  logic        msb_q, msb_d;
  logic [15:0] ent_q, ent_d;

  logic        in_fire;
  logic        out_fire;
  logic        big_end;
  logic [1:0]  idx;
  logic [2:0]  idx_inc;
  logic [2:0]  flen;
  logic [2:0]  sig_pos;
  logic [31:0] asm_val;
  logic [15:0] ent_dec;
  logic        res_valid;
  logic [3:0]  res_status;
  logic [15:0] res_value;

  logic        out_valid_q;
  logic [3:0]  out_status_q;
  logic [15:0] out_value_q;
  logic        skid_valid_q;
  logic [3:0]  skid_status_q;
  logic [15:0] skid_value_q;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // field assembly in the byte order of the current phase
  assign idx     = fbi_q[1:0];
  assign idx_inc = {1'b0, idx} + 3'd1;
  assign flen    = (phase_q == PH_OFFSET || phase_q == PH_TCOUNT) ? 3'd4 : 3'd2;
  assign big_end = (phase_q >= PH_MAGIC) ? msb_q : 1'b1;
  assign asm_val = big_end ? {shift_q[23:0], data_byte_i}
                           : (shift_q | ({24'd0, data_byte_i} << {idx, 3'b000}));
  assign sig_pos = (fbi_q > SIG_LAST_POS) ? SIG_LAST_POS : fbi_q;
  assign ent_dec = ent_q - 16'd1;

  // parse step for the accepted byte
  always_comb begin
    phase_d    = phase_q;
    fbi_d      = fbi_q;
    shift_d    = shift_q;
    skip_d     = skip_q;
    msb_d      = msb_q;
    ent_d      = ent_q;
    res_valid  = 1'b0;
    res_status = ST_FOUND;
    res_value  = 16'd0;
    if (in_fire) begin
      if (phase_q inside {PH_SKIPSEG, PH_SKIPIFD, PH_SKIPENT}) begin
        skip_d = skip_q - 32'd1;
        if (skip_q == 32'd1) begin
          case (phase_q)
            PH_SKIPSEG: phase_d = PH_MARKER;
            PH_SKIPIFD: phase_d = PH_COUNT;
            default:    phase_d = PH_TAG;
          endcase
        end
      end else if (phase_q == PH_SIG) begin
        if (data_byte_i != sig_byte(sig_pos)) begin
          res_valid  = 1'b1;
          res_status = ST_BAD_SIG;
        end else if (sig_pos == SIG_LAST_POS) begin
          fbi_d   = 3'd0;
          phase_d = PH_ORDER;
        end else begin
          fbi_d = sig_pos + 3'd1;
        end
      end else if (phase_q != PH_DONE) begin
        if (idx_inc >= flen) begin
          fbi_d   = 3'd0;
          shift_d = 32'd0;
          // whole field present: act on it
          case (phase_q)
            PH_SOI: begin
              if (asm_val != MK_SOI) begin
                res_valid  = 1'b1;
                res_status = ST_NOT_JPEG;
              end else begin
                phase_d = PH_MARKER;
              end
            end
            PH_MARKER: begin
              if (asm_val == MK_SOS || asm_val == MK_EOI) begin
                res_valid  = 1'b1;
                res_status = ST_NO_EXIF;
              end else begin
                phase_d = (asm_val == MK_APP1) ? PH_APPLEN : PH_LENGTH;
              end
            end
            PH_LENGTH: begin
              if (asm_val < SEG_LEN_MIN) begin
                res_valid  = 1'b1;
                res_status = ST_MALFORMED;
              end else if (asm_val == SEG_LEN_MIN) begin
                phase_d = PH_MARKER;
              end else begin
                skip_d  = asm_val - SEG_LEN_MIN;
                phase_d = PH_SKIPSEG;
              end
            end
            PH_APPLEN: phase_d = PH_SIG;
            PH_ORDER: begin
              if (asm_val == TIFF_LE) begin
                msb_d   = 1'b0;
                phase_d = PH_MAGIC;
              end else if (asm_val == TIFF_BE) begin
                msb_d   = 1'b1;
                phase_d = PH_MAGIC;
              end else begin
                res_valid  = 1'b1;
                res_status = ST_BAD_TIFF;
              end
            end
            PH_MAGIC: begin
              if (asm_val != TIFF_MAGIC) begin
                res_valid  = 1'b1;
                res_status = ST_BAD_TIFF;
              end else begin
                phase_d = PH_OFFSET;
              end
            end
            PH_OFFSET: begin
              if (asm_val < IFD_OFS_MIN) begin
                res_valid  = 1'b1;
                res_status = ST_MALFORMED;
              end else if (asm_val == IFD_OFS_MIN) begin
                phase_d = PH_COUNT;
              end else begin
                skip_d  = asm_val - IFD_OFS_MIN;
                phase_d = PH_SKIPIFD;
              end
            end
            PH_COUNT: begin
              if (asm_val == 32'd0) begin
                res_valid  = 1'b1;
                res_status = ST_TAG_ABSENT;
              end else begin
                ent_d   = asm_val[15:0];
                phase_d = PH_TAG;
              end
            end
            PH_TAG: begin
              if (asm_val == TAG_ORIENT) begin
                phase_d = PH_TYPE;
              end else begin
                ent_d = ent_dec;
                if (ent_dec == 16'd0) begin
                  res_valid  = 1'b1;
                  res_status = ST_TAG_ABSENT;
                end else begin
                  skip_d  = ENTRY_REST;
                  phase_d = PH_SKIPENT;
                end
              end
            end
            PH_TYPE: phase_d = PH_TCOUNT;
            PH_TCOUNT: begin
              if (asm_val != 32'd1) begin
                res_valid  = 1'b1;
                res_status = ST_BAD_COUNT;
              end else begin
                phase_d = PH_VALUE;
              end
            end
            PH_VALUE: begin
              res_valid  = 1'b1;
              res_status = ST_FOUND;
              res_value  = asm_val[15:0];
            end
            default: ;
          endcase
        end else begin
          fbi_d   = idx_inc;
          shift_d = asm_val;
        end
      end
      if (res_valid) begin
        phase_d = PH_DONE;
      end
      // last byte: truncation check, then rearm
      if (last_byte_i) begin
        if (!res_valid && phase_q != PH_DONE) begin
          res_valid  = 1'b1;
          res_status = ST_TRUNCATED;
          res_value  = 16'd0;
        end
        phase_d = PH_SOI;
        fbi_d   = 3'd0;
        shift_d = 32'd0;
        skip_d  = 32'd0;
        msb_d   = 1'b0;
        ent_d   = 16'd0;
      end
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SOI;
      fbi_q   <= 3'd0;
      shift_q <= 32'd0;
      skip_q  <= 32'd0;
      msb_q   <= 1'b0;
      ent_q   <= 16'd0;
    end else begin
      phase_q <= phase_d;
      fbi_q   <= fbi_d;
      shift_q <= shift_d;
      skip_q  <= skip_d;
      msb_q   <= msb_d;
      ent_q   <= ent_d;
    end
  end

  // output register and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (res_valid) begin
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payloads
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_status_q <= skid_status_q;
        out_value_q  <= skid_value_q;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_fire) begin
        out_status_q <= res_status;
        out_value_q  <= res_value;
      end else begin
        skid_status_q <= res_status;
        skid_value_q  <= res_value;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign orientation_o = out_value_q;

  // checks
  `ASSERT_PROP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q)
  `ASSERT_PROP(a_last_rearms, clk_i, rst_ni, (in_fire && last_byte_i) |=> (phase_q == PH_SOI))
  `ASSERT_NEVER(a_err_has_value, clk_i, rst_ni,
                out_valid_q && (out_status_q != ST_FOUND) && (out_value_q != 16'd0))
  `ASSERT_NEVER(a_phase_range, clk_i, rst_ni, phase_q > PH_DONE)

endmodule

// File: dv/jpeg_exif_orientation_checker.sv
// checker for the orientation parser: tracks each accepted byte and compares the reports
module jpeg_exif_orientation_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  status_i,
  input  logic [15:0] orientation_i,
  output int          fail_cnt_o,
  output int          waiting_o,
  output int          parsed_o,
  output int          reports_o,
  output int          found_o
);
  import jeop_pkg::*;

  // "Exif\0\0", first byte in the top bits
  localparam logic [47:0] EXIF_ID = 48'h4578_6966_0000;

  // tracked parser state
  logic [4:0]  phase_q;
  logic [2:0]  byte_idx_q;
  logic [31:0] shift_q;
  logic [31:0] skip_q;
  logic        msb_q;
  logic [15:0] entries_q;
  logic        given_q;
  bit          reported;

  // reports still owed by the parser, oldest first
  logic [3:0]  status_q[$];
  logic [15:0] orient_q[$];

  task automatic clear_parse();
    phase_q    = PH_SOI;
    byte_idx_q = '0;
    shift_q    = '0;
    skip_q     = '0;
    msb_q      = 1'b0;
    entries_q  = '0;
    given_q    = 1'b0;
  endtask

  task automatic report(input logic [3:0] st, input logic [15:0] val);
    status_q.push_back(st);
    orient_q.push_back(val);
    phase_q  = PH_DONE;
    given_q  = 1'b1;
    reported = 1'b1;
  endtask

  // act on a complete field of the current phase
  task automatic decode_field(input logic [31:0] v);
    case (phase_q)
      PH_SOI: begin
        if (v != MK_SOI) report(ST_NOT_JPEG, '0);
        else phase_q = PH_MARKER;
      end
      PH_MARKER: begin
        if (v == MK_SOS || v == MK_EOI) report(ST_NO_EXIF, '0);
        else phase_q = (v == MK_APP1) ? PH_APPLEN : PH_LENGTH;
      end
      PH_LENGTH: begin
        if (v < SEG_LEN_MIN) begin
          report(ST_MALFORMED, '0);
        end else if (v == SEG_LEN_MIN) begin
          phase_q = PH_MARKER;
        end else begin
          skip_q  = v - SEG_LEN_MIN;
          phase_q = PH_SKIPSEG;
        end
      end
      PH_APPLEN: phase_q = PH_SIG;
      PH_ORDER: begin
        if (v == TIFF_LE) begin
          msb_q   = 1'b0;
          phase_q = PH_MAGIC;
        end else if (v == TIFF_BE) begin
          msb_q   = 1'b1;
          phase_q = PH_MAGIC;
        end else begin
          report(ST_BAD_TIFF, '0);
        end
      end
      PH_MAGIC: begin
        if (v != TIFF_MAGIC) report(ST_BAD_TIFF, '0);
        else phase_q = PH_OFFSET;
      end
      PH_OFFSET: begin
        if (v < IFD_OFS_MIN) begin
          report(ST_MALFORMED, '0);
        end else if (v == IFD_OFS_MIN) begin
          phase_q = PH_COUNT;
        end else begin
          skip_q  = v - IFD_OFS_MIN;
          phase_q = PH_SKIPIFD;
        end
      end
      PH_COUNT: begin
        if (v == 32'd0) begin
          report(ST_TAG_ABSENT, '0);
        end else begin
          entries_q = v[15:0];
          phase_q   = PH_TAG;
        end
      end
      PH_TAG: begin
        if (v == TAG_ORIENT) begin
          phase_q = PH_TYPE;
        end else begin
          entries_q = entries_q - 16'd1;
          if (entries_q == 16'd0) begin
            report(ST_TAG_ABSENT, '0);
          end else begin
            skip_q  = ENTRY_REST;
            phase_q = PH_SKIPENT;
          end
        end
      end
      PH_TYPE: phase_q = PH_TCOUNT;
      PH_TCOUNT: begin
        if (v != 32'd1) report(ST_BAD_COUNT, '0);
        else phase_q = PH_VALUE;
      end
      PH_VALUE: report(ST_FOUND, v[15:0]);
      default: ;
    endcase
  endtask

  // advance the tracked state by one file byte
  task automatic follow_byte(input logic [7:0] b, input logic lst);
    logic [2:0]  pos;
    logic [31:0] v;
    int          flen;
    int          idx;
    logic        msb;
    reported = 1'b0;
    if (!given_q && phase_q < PH_DONE) begin
      parsed_o = parsed_o + 1;
      if (phase_q == PH_SKIPSEG || phase_q == PH_SKIPIFD || phase_q == PH_SKIPENT) begin
        skip_q = skip_q - 32'd1;
        if (skip_q == 32'd0)
          phase_q = (phase_q == PH_SKIPSEG) ? PH_MARKER :
                    (phase_q == PH_SKIPIFD) ? PH_COUNT : PH_TAG;
      end else if (phase_q == PH_SIG) begin
        pos = (byte_idx_q > SIG_LAST_POS) ? SIG_LAST_POS : byte_idx_q;
        if (b != EXIF_ID[47 - 8*pos -: 8]) begin
          report(ST_BAD_SIG, '0);
        end else if (pos == SIG_LAST_POS) begin
          byte_idx_q = '0;
          phase_q    = PH_ORDER;
        end else begin
          byte_idx_q = pos + 3'd1;
        end
      end else begin
        // markers and lengths are big-endian, tiff fields follow the order mark
        flen = (phase_q == PH_OFFSET || phase_q == PH_TCOUNT) ? 4 : 2;
        msb  = (phase_q >= PH_MAGIC) ? msb_q : 1'b1;
        idx  = int'(byte_idx_q[1:0]);
        if (msb) shift_q = {shift_q[23:0], b};
        else shift_q = shift_q | ({24'd0, b} << (8 * idx));
        idx = idx + 1;
        if (idx >= flen) begin
          v          = shift_q;
          byte_idx_q = '0;
          shift_q    = '0;
          decode_field(v);
        end else begin
          byte_idx_q = idx[2:0];
        end
      end
    end
    // end of file: truncated if nothing was said, then rearm
    if (lst) begin
      if (!reported && !given_q) report(ST_TRUNCATED, '0);
      clear_parse();
    end
  endtask

  // predict on accepted bytes, compare accepted reports
  always @(posedge clk_i or negedge rst_ni) begin
    logic [3:0]  exp_st;
    logic [15:0] exp_or;
    if (!rst_ni) begin
      clear_parse();
      status_q.delete();
      orient_q.delete();
      fail_cnt_o = 0;
      waiting_o  = 0;
      parsed_o   = 0;
      reports_o  = 0;
      found_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) follow_byte(data_byte_i, last_byte_i);
      if (out_valid_i && out_ready_i) begin
        reports_o = reports_o + 1;
        if (status_q.size() == 0) begin
          $display("%0t: report with none owed: status=%0d orientation=%h",
                   $time, status_i, orientation_i);
          fail_cnt_o = fail_cnt_o + 1;
        end else begin
          exp_st = status_q.pop_front();
          exp_or = orient_q.pop_front();
          if (status_i !== exp_st) begin
            $display("%0t: status expected %0d, got %0d", $time, exp_st, status_i);
            fail_cnt_o = fail_cnt_o + 1;
          end
          if (orientation_i !== exp_or) begin
            $display("%0t: orientation expected %h, got %h", $time, exp_or, orientation_i);
            fail_cnt_o = fail_cnt_o + 1;
          end
          if (exp_st == ST_FOUND) found_o = found_o + 1;
        end
      end
      waiting_o = status_q.size();
    end
  end

endmodule

// File: dv/jpeg_exif_orientation_parser_tb.sv
// testbench top for the orientation parser: file stimulus, ready pattern and verdict
module jpeg_exif_orientation_parser_tb;
  import jeop_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  status_o;
  logic [15:0] orientation_o;

  int fail_cnt;
  int waiting;
  int parsed_cnt;
  int report_cnt;
  int found_cnt;

  // file under construction, sent front to back
  logic [7:0] file_q[$];
  bit calm;
  int files_sent;
  int bytes_sent;

  jpeg_exif_orientation_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .orientation_o (orientation_o)
  );

  jpeg_exif_orientation_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status_o),
    .orientation_i (orientation_o),
    .fail_cnt_o    (fail_cnt),
    .waiting_o     (waiting),
    .parsed_o      (parsed_cnt),
    .reports_o     (report_cnt),
    .found_o       (found_cnt)
  );

  always #6 clk_i = ~clk_i;

  // receiver stalls at random outside the calm stretch
  always @(negedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 32);

  initial begin
    #1200000;
    $display("timeout with %0d reports outstanding", waiting);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic put16(input logic [15:0] v, input logic msb);
    if (msb) begin
      file_q.push_back(v[15:8]);
      file_q.push_back(v[7:0]);
    end else begin
      file_q.push_back(v[7:0]);
      file_q.push_back(v[15:8]);
    end
  endtask

  task automatic put32(input logic [31:0] v, input logic msb);
    if (msb) begin
      put16(v[31:16], 1'b1);
      put16(v[15:0], 1'b1);
    end else begin
      put16(v[15:0], 1'b0);
      put16(v[31:16], 1'b0);
    end
  endtask

  // soi, optional filler segments, app1 with signature, tiff order and magic
  task automatic exif_head(input logic msb, input int nseg);
    logic [7:0] mk;
    int         len;
    put16(MK_SOI[15:0], 1'b1);
    for (int s = 0; s < nseg; s++) begin
      mk = 8'($urandom_range(255));
      if (mk == MK_APP1[7:0] || mk == MK_SOS[7:0] || mk == MK_EOI[7:0]) mk = 8'hE0;
      // now and then end the search early with start of scan or end of image
      if ($urandom_range(99) < 4) mk = $urandom_range(1) ? MK_SOS[7:0] : MK_EOI[7:0];
      put16({8'hFF, mk}, 1'b1);
      len = $urandom_range(2, 10);
      put16(16'(len), 1'b1);
      repeat (len - 2) file_q.push_back(8'($urandom_range(255)));
    end
    put16(MK_APP1[15:0], 1'b1);
    put16(16'($urandom_range(65535)), 1'b1);
    put32(32'h4578_6966, 1'b1);
    put16(16'h0000, 1'b1);
    put16(msb ? TIFF_BE[15:0] : TIFF_LE[15:0], 1'b1);
    put16(TIFF_MAGIC[15:0], msb);
  endtask

  // one byte on the input channel, random idle cycles ahead of it unless calm
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (!calm)
      while ($urandom_range(99) < 32) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    in_valid_i  = 1'b1;
    data_byte_i = b;
    last_byte_i = lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent = bytes_sent + 1;
    @(negedge clk_i);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    files_sent = files_sent + 1;
    file_q.delete();
  endtask

  // hold the input until every owed report has come out
  task automatic drain();
    if (waiting != 0) begin
      in_valid_i = 1'b0;
      while (waiting != 0) @(negedge clk_i);
    end
  endtask

  // mostly well-formed exif files with random content, some broken, some noise
  task automatic make_file();
    logic        msb;
    logic [15:0] tag;
    int          kind;
    int          ofs;
    int          cnt;
    int          opos;
    int          pick;
    kind = $urandom_range(99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 24)) file_q.push_back(8'($urandom_range(255)));
    end else begin
      msb = $urandom_range(1);
      exif_head(msb, $urandom_range(0, 3));
      ofs = $urandom_range(8, 16);
      put32(32'(ofs), msb);
      repeat (ofs - 8) file_q.push_back(8'($urandom_range(255)));
      cnt  = $urandom_range(1, 4);
      opos = $urandom_range(0, cnt);
      put16(16'(cnt), msb);
      for (int e = 0; e < cnt; e++) begin
        if (e == opos) begin
          put16(TAG_ORIENT[15:0], msb);
          put16(16'($urandom_range(65535)), msb);
          put32(($urandom_range(9) == 0) ? 32'($urandom) : 32'd1, msb);
          put16($urandom_range(1) ? 16'($urandom_range(1, 8)) : 16'($urandom_range(65535)),
                msb);
          put16(16'($urandom_range(65535)), msb);
        end else begin
          tag = 16'($urandom_range(65535));
          if (tag == TAG_ORIENT[15:0]) tag = tag + 16'd1;
          put16(tag, msb);
          repeat (10) file_q.push_back(8'($urandom_range(255)));
        end
      end
      repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom_range(255)));
      // broken files: a flipped byte or an early end
      if ($urandom_range(99) < 12) begin
        pick = $urandom_range(file_q.size() - 1);
        file_q[pick] = file_q[pick] ^ 8'($urandom_range(1, 255));
      end
      if ($urandom_range(99) < 10) begin
        pick = $urandom_range(1, file_q.size());
        while (file_q.size() > pick) void'(file_q.pop_back());
      end
    end
  endtask

  initial begin
    int rnd_files;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    calm        = 1'b0;
    files_sent  = 0;
    bytes_sent  = 0;
    rnd_files   = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // wrong start of image, result on the last byte
    put16(16'hFFD7, 1'b1);
    send_file();
    // start of scan right after soi, trailing bytes ignored
    put16(MK_SOI[15:0], 1'b1);
    put16(MK_SOS[15:0], 1'b1);
    put16(16'h0000, 1'b1);
    send_file();
    // end of image before any app1
    put16(MK_SOI[15:0], 1'b1);
    put16(MK_EOI[15:0], 1'b1);
    send_file();
    // segment length below two
    put16(MK_SOI[15:0], 1'b1);
    put16(16'hFFC0, 1'b1);
    put16(16'h0001, 1'b1);
    send_file();
    // empty segment of length two, then a bad signature byte
    put16(MK_SOI[15:0], 1'b1);
    put16(16'hFFFE, 1'b1);
    put16(16'h0002, 1'b1);
    put16(MK_APP1[15:0], 1'b1);
    put16(16'h0010, 1'b1);
    put32(32'h4578_6946, 1'b1);
    send_file();
    // byte order mark neither II nor MM
    exif_head(1'b0, 0);
    file_q[file_q.size() - 3] = 8'h48;
    send_file();
    // wrong tiff magic
    exif_head(1'b0, 0);
    file_q[file_q.size() - 2] = file_q[file_q.size() - 2] ^ 8'h01;
    send_file();
    // ifd offset below eight
    exif_head(1'b1, 0);
    put32(32'd7, 1'b1);
    send_file();
    // ifd with no entries
    exif_head(1'b0, 0);
    put32(32'd8, 1'b0);
    put16(16'd0, 1'b0);
    send_file();
    // gap before ifd0, single entry that is not orientation
    exif_head(1'b1, 0);
    put32(32'd10, 1'b1);
    put16(16'hFFFF, 1'b1);
    put16(16'd1, 1'b1);
    put16(16'h0113, 1'b1);
    send_file();
    // orientation entry with a count other than one
    exif_head(1'b0, 0);
    put32(32'd8, 1'b0);
    put16(16'd2, 1'b0);
    put16(16'h0100, 1'b0);
    repeat (10) file_q.push_back(8'h00);
    put16(TAG_ORIENT[15:0], 1'b0);
    put16(16'd3, 1'b0);
    put32(32'd2, 1'b0);
    send_file();
    // big-endian orientation at the top of the range, trailing bytes
    exif_head(1'b1, 0);
    put32(32'd8, 1'b1);
    put16(16'd1, 1'b1);
    put16(TAG_ORIENT[15:0], 1'b1);
    put16(16'd3, 1'b1);
    put32(32'd1, 1'b1);
    put16(16'hFFFF, 1'b1);
    put16(16'hFF00, 1'b1);
    send_file();
    // little-endian orientation of zero, largest entry count
    exif_head(1'b0, 0);
    put32(32'd8, 1'b0);
    put16(16'hFFFF, 1'b0);
    put16(TAG_ORIENT[15:0], 1'b0);
    put16(16'd3, 1'b0);
    put32(32'd1, 1'b0);
    put16(16'h0000, 1'b0);
    send_file();
    // one-byte file and a file cut inside the entry count
    file_q.push_back(8'hFF);
    send_file();
    exif_head(1'b0, 0);
    put32(32'd8, 1'b0);
    file_q.push_back(8'h01);
    send_file();
    drain();

    // random files until enough bytes have been sent
    while (bytes_sent < 950) begin
      calm = (rnd_files >= 20 && rnd_files < 32);
      make_file();
      send_file();
      rnd_files = rnd_files + 1;
      if ($urandom_range(11) == 0) drain();
    end
    calm       = 1'b0;
    in_valid_i = 1'b0;

    while (waiting != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("sent %0d files (%0d bytes, %0d parsed), checked %0d reports, %0d with a value",
             files_sent, bytes_sent, parsed_cnt, report_cnt, found_cnt);
    if (fail_cnt == 0 && waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/jeop_pkg.sv
sv/jpeg_exif_orientation_parser.sv
dv/jpeg_exif_orientation_checker.sv
dv/jpeg_exif_orientation_parser_tb.sv
